// File: hdl/ufbs_pkg.sv
`timescale 1ns / 1ps

package ufbs_pkg;

  // field widths
  localparam int unsigned CLK_W  = 28;
  localparam int unsigned BAUD_W = 24;
  localparam int unsigned DL_W   = 16;
  localparam int unsigned DA_W   = 4;
  localparam int unsigned MUL_W  = 4;

  localparam int unsigned MUL_MAX = 15;
  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(60000000);

  // search arithmetic widths
  localparam int unsigned SUM_W  = $clog2(2 * MUL_MAX);         // mul + div_add
  localparam int unsigned D1_W   = DL_W + 4;                    // 16 * divisor
  localparam int unsigned D_W    = D1_W + SUM_W;                // 16 * dl * (mul + dadd)
  localparam int unsigned A1_W   = BAUD_W + D1_W;
  localparam int unsigned A_W    = BAUD_W + D_W;
  localparam int unsigned B_W    = CLK_W + MUL_W;
  localparam int unsigned N_W    = (A_W > B_W) ? A_W : B_W;
  localparam int unsigned SQ_W   = 2 * BAUD_W;
  localparam int unsigned ACC_W  = N_W + D_W + 2;
  localparam int unsigned N1K_W  = N_W + 10;
  localparam int unsigned CNT_W  = $clog2(D_W);
  localparam int unsigned DCNT_W = $clog2(CLK_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PLAN,
    ST_DLINIT,
    ST_CAND,
    ST_CMP,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic start;
  } cmp_ctrl_t;

  typedef struct packed {
    logic done;
    logic less;
  } cmp_stat_t;

endpackage

// File: hdl/ufbs_if.sv
`timescale 1ns / 1ps

interface ufbs_in_if ();
  import ufbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [BAUD_W-1:0] baud_rate;
  modport source (output valid, output baud_rate, input ready);
  modport sink (input valid, input baud_rate, output ready);
endinterface

interface ufbs_out_if ();
  import ufbs_pkg::*;
  logic             valid;
  logic             ready;
  logic [DL_W-1:0]  divisor_latch;
  logic [DA_W-1:0]  div_add;
  logic [MUL_W-1:0] multiplier;
  modport source (output valid, output divisor_latch, output div_add, output multiplier,
                  input ready);
  modport sink (input valid, input divisor_latch, input div_add, input multiplier,
                output ready);
endinterface

interface ufbs_cfg_if ();
  import ufbs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CLK_W-1:0] clock_hz;
  modport source (output valid, output clock_hz, input ready);
  modport sink (input valid, input clock_hz, output ready);
endinterface

// File: hdl/ufbs_xcmp.sv
`timescale 1ns / 1ps

// Serial exact compare: less = (lhs_a * lhs_b) < (rhs_a * rhs_b).
// MSB-first over the B operands, one signed add/sub step per cycle.
// Operands must hold from start until done.
module ufbs_xcmp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ufbs_pkg::cmp_ctrl_t      ctrl_i,
  input  logic [ufbs_pkg::N_W-1:0] lhs_a_i,
  input  logic [ufbs_pkg::D_W-1:0] lhs_b_i,
  input  logic [ufbs_pkg::N_W-1:0] rhs_a_i,
  input  logic [ufbs_pkg::D_W-1:0] rhs_b_i,
  output ufbs_pkg::cmp_stat_t      stat_o
);
  import ufbs_pkg::*;

  logic                    busy_q;
  logic                    done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;
  logic signed [ACC_W-1:0] add_t;
  logic signed [ACC_W-1:0] sub_t;

  always_comb begin
    add_t = lhs_b_i[cnt_q] ? ACC_W'(lhs_a_i) : '0;
    sub_t = rhs_b_i[cnt_q] ? ACC_W'(rhs_a_i) : '0;
    acc_d = (acc_q <<< 1) + add_t - sub_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(D_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.less = acc_q[ACC_W-1];

endmodule

// File: hdl/uart_fractional_baud_search_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                  Accept
// cfg_i     in   clock_hz[27:0]                           valid & ready (ready always high)
// in_i      in   baud_rate[23:0]                          valid & ready (ready only when idle)
// out_o     out  divisor_latch[15:0], div_add, multiplier valid & ready
//
// Steps per request: accept, 28 restoring-divide steps, plan; then for every divisor
// tried an init step and 120 fractional pairs (each pair forms N, then runs the serial
// cross-multiply compare unit), then the result register is loaded.
// Exact divisions and rates above clock/16 finish after the divide and plan; a zero
// rate skips the divide.
// Reset brings clock_hz to 60000000 and the block to idle with no result pending.
// A result waiting on out_o does not block the next request; the search stalls at its
// end only if the previous result is still not taken.
module uart_fractional_baud_search_core (
  input  logic    clk_i,
  input  logic    rst_ni,
  ufbs_cfg_if.sink   cfg_i,
  ufbs_in_if.sink    in_i,
  ufbs_out_if.source out_o
);
  import ufbs_pkg::*;

  st_e state_q, state_d;

  logic [CLK_W-1:0]  clock_q;
  logic [BAUD_W-1:0] baud_q;
  logic [SQ_W-1:0]   sq_q;
  logic [CLK_W-1:0]  rem_q;
  logic [CLK_W-1:0]  quo_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [DL_W-1:0]   q_q;
  logic [DL_W-1:0]   dlv_q;
  logic [MUL_W-1:0]  mv_q;
  logic [DA_W-1:0]   dav_q;
  logic [A1_W-1:0]   a1_q;
  logic [A_W-1:0]    am_q;
  logic [A_W-1:0]    a_q;
  logic [D1_W-1:0]   d1_q;
  logic [D_W-1:0]    dm_q;
  logic [D_W-1:0]    d_q;
  logic [B_W-1:0]    b_q;
  logic [N_W-1:0]    n_q;
  logic [N1K_W-1:0]  n1k_q;
  logic [N_W-1:0]    bestn_q;
  logic [D_W-1:0]    bestd_q;
  logic              hit_q;
  logic [DL_W-1:0]   dl_q;
  logic [DA_W-1:0]   da_q;
  logic [MUL_W-1:0]  mu_q;
  logic              ov_q;
  logic [DL_W-1:0]   odl_q;
  logic [DA_W-1:0]   oda_q;
  logic [MUL_W-1:0]  omu_q;

  cmp_ctrl_t cmp_ctrl;
  cmp_stat_t cmp_stat;

  logic [CLK_W-1:0]       den;
  logic [CLK_W:0]         rsh;
  logic                   dge;
  logic [CLK_W:0]         rdiff;
  logic [DL_W-1:0]        qsat;
  logic [DL_W-1:0]        dlv_start;
  logic [BAUD_W+DL_W-1:0] a1_prod;
  logic [A1_W-1:0]        a1_new;
  logic [N_W-1:0]         aw;
  logic [N_W-1:0]         bw;
  logic [N_W-1:0]         n_new;
  logic [N1K_W-1:0]       n1k_new;
  logic                   hit_c;
  logic                   better;
  logic                   hit_all;
  logic                   last_dav;
  logic                   last_mv;
  logic                   load_out;
  logic                   accept;

  // restoring divide of clock by 16*baud, one quotient bit per cycle
  always_comb begin
    den   = CLK_W'({baud_q, 4'b0000});
    rsh   = {rem_q, clock_q[dcnt_q]};
    dge   = rsh >= {1'b0, den};
    rdiff = rsh - {1'b0, den};
  end

  always_comb begin
    qsat      = (|quo_q[CLK_W-1:DL_W]) ? '1 : quo_q[DL_W-1:0];
    dlv_start = ((qsat >> 1) == '0) ? DL_W'(1) : (qsat >> 1);
    a1_prod   = baud_q * dlv_q;
    a1_new    = A1_W'({a1_prod, 4'b0000});
    aw        = N_W'(a_q);
    bw        = N_W'(b_q);
    n_new     = (aw > bw) ? (aw - bw) : (bw - aw);
    // N * 1000 = N*1024 - N*16 - N*8
    n1k_new   = (N1K_W'(n_q) << 10) - (N1K_W'(n_q) << 4) - (N1K_W'(n_q) << 3);
    hit_c     = n1k_q < N1K_W'(a_q);
    better    = cmp_stat.done & cmp_stat.less;
    hit_all   = hit_q | (better & hit_c);
    last_dav  = dav_q == (mv_q - MUL_W'(1));
    last_mv   = mv_q == MUL_W'(MUL_MAX);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = (in_i.baud_rate == '0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt_q == '0) begin
          state_d = ST_PLAN;
        end
      end
      ST_PLAN: begin
        state_d = (rem_q == '0 || qsat == '0) ? ST_DONE : ST_DLINIT;
      end
      ST_DLINIT: state_d = ST_CAND;
      ST_CAND:   state_d = ST_CMP;
      ST_CMP: begin
        if (cmp_stat.done) begin
          if (!last_dav || !last_mv) begin
            state_d = ST_CAND;
          end else if (hit_all || dlv_q == q_q) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_DLINIT;
          end
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready     = state_q == ST_IDLE;
    cmp_ctrl.start = state_q == ST_CAND;
    load_out       = (state_q == ST_DONE) && (!ov_q || out_o.ready);
  end

  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clock_q <= CLK_RESET;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        clock_q <= cfg_i.clock_hz;
      end
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          baud_q <= in_i.baud_rate;
          sq_q   <= in_i.baud_rate * in_i.baud_rate;
          rem_q  <= '0;
          quo_q  <= '0;
          dcnt_q <= DCNT_W'(CLK_W - 1);
          dl_q   <= '0;
          da_q   <= '0;
          mu_q   <= MUL_W'(1);
        end
      end
      ST_DIV: begin
        rem_q  <= dge ? rdiff[CLK_W-1:0] : rsh[CLK_W-1:0];
        quo_q  <= {quo_q[CLK_W-2:0], dge};
        dcnt_q <= dcnt_q - DCNT_W'(1);
      end
      ST_PLAN: begin
        q_q     <= qsat;
        dl_q    <= qsat;
        dlv_q   <= dlv_start;
        // error to beat starts at baud squared: N/D < baud^2*D/D
        bestn_q <= N_W'(sq_q);
        bestd_q <= D_W'(1);
        hit_q   <= 1'b0;
      end
      ST_DLINIT: begin
        a1_q  <= a1_new;
        am_q  <= A_W'(a1_new);
        a_q   <= A_W'(a1_new);
        d1_q  <= D1_W'({dlv_q, 4'b0000});
        dm_q  <= D_W'({dlv_q, 4'b0000});
        d_q   <= D_W'({dlv_q, 4'b0000});
        b_q   <= B_W'(clock_q);
        mv_q  <= MUL_W'(1);
        dav_q <= '0;
      end
      ST_CAND: begin
        n_q <= n_new;
      end
      ST_CMP: begin
        n1k_q <= n1k_new;
        if (cmp_stat.done) begin
          hit_q <= hit_all;
          if (better) begin
            bestn_q <= n_q;
            bestd_q <= d_q;
            dl_q    <= dlv_q;
            da_q    <= dav_q;
            mu_q    <= mv_q;
          end
          if (!last_dav) begin
            dav_q <= dav_q + DA_W'(1);
            a_q   <= a_q + A_W'(a1_q);
            d_q   <= d_q + D_W'(d1_q);
          end else if (!last_mv) begin
            mv_q  <= mv_q + MUL_W'(1);
            dav_q <= '0;
            am_q  <= am_q + A_W'(a1_q);
            a_q   <= am_q + A_W'(a1_q);
            dm_q  <= dm_q + D_W'(d1_q);
            d_q   <= dm_q + D_W'(d1_q);
            b_q   <= b_q + B_W'(clock_q);
          end else if (!(hit_all || dlv_q == q_q)) begin
            dlv_q <= dlv_q + DL_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (load_out) begin
          odl_q <= dl_q;
          oda_q <= da_q;
          omu_q <= mu_q;
        end
      end
      default: begin
      end
    endcase
  end

  ufbs_xcmp u_xcmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cmp_ctrl),
    .lhs_a_i (n_q),
    .lhs_b_i (bestd_q),
    .rhs_a_i (bestn_q),
    .rhs_b_i (d_q),
    .stat_o  (cmp_stat)
  );

  assign out_o.valid         = ov_q;
  assign out_o.divisor_latch = odl_q;
  assign out_o.div_add       = oda_q;
  assign out_o.multiplier    = omu_q;

endmodule

// File: hdl/ufbs_checker.sv
`timescale 1ns / 1ps

module ufbs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [ufbs_pkg::DL_W-1:0]  divisor_latch_i,
  input logic [ufbs_pkg::DA_W-1:0]  div_add_i,
  input logic [ufbs_pkg::MUL_W-1:0] multiplier_i
);
  import ufbs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(divisor_latch_i)
      && $stable(div_add_i) && $stable(multiplier_i))
    else $error("result changed while stalled");

  a_frac_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> div_add_i < multiplier_i)
    else $error("div_add not below multiplier");

  a_mul_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> multiplier_i != '0 && multiplier_i <= MUL_W'(MUL_MAX))
    else $error("multiplier out of range");

  // a fractional setting only comes out of the search, which never tries divisor zero
  a_frac_nonzero_dl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && div_add_i != '0 |-> divisor_latch_i != '0)
    else $error("fractional result with zero divisor");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after a request transaction");

endmodule

bind uart_fractional_baud_search_core ufbs_checker u_ufbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .divisor_latch_i (out_o.divisor_latch),
  .div_add_i       (out_o.div_add),
  .multiplier_i    (out_o.multiplier)
);

// File: bench/uart_fractional_baud_search_core_test.sv
`timescale 1ns / 1ps

module uart_fractional_baud_search_core_test;
  import ufbs_pkg::*;

  localparam int unsigned QUIET_LIMIT = 200000;

  typedef struct packed {
    logic [DL_W-1:0]  dl;
    logic [DA_W-1:0]  da;
    logic [MUL_W-1:0] mul;
  } divisor_set_t;

  class divisor_scoreboard;
    logic [CLK_W-1:0] clock_hz;
    divisor_set_t     expected_divisors[$];

    function new();
      clock_hz = CLK_RESET;
    endfunction

    function logic [127:0] wide_product(longint unsigned x, longint unsigned y);
      logic [127:0] wx, wy;
      wx = x;
      wy = y;
      return wx * wy;
    endfunction

    // Exhaustive divisor / fraction search with exact error comparison
    function divisor_set_t compute_divisors(logic [BAUD_W-1:0] baud_rate);
      longint unsigned clk, baud, den, q, rem, dlv, mv, dav;
      longint unsigned d, a, b, n, best_n, best_d;
      bit have, hit, better;
      divisor_set_t res;
      clk = clock_hz;
      baud = baud_rate;
      res = '{dl: '0, da: '0, mul: MUL_W'(1)};
      have = 1'b0;
      hit = 1'b0;
      best_n = 0;
      best_d = 1;
      if (baud != 0) begin
        den = 16 * baud;
        q = clk / den;
        rem = clk % den;
        if (q > 65535) q = 65535;
        res.dl = q[DL_W-1:0];
        if (rem != 0) begin
          for (dlv = q / 2; dlv <= q && !hit; dlv++) begin
            if (dlv == 0) continue;
            for (mv = 1; mv <= MUL_MAX; mv++) begin
              for (dav = 0; dav < mv; dav++) begin
                d = 16 * dlv * (mv + dav);
                a = baud * d;
                b = clk * mv;
                n = (a > b) ? a - b : b - a;
                if (have)
                  better = wide_product(n, best_d) < wide_product(best_n, d);
                else
                  better = wide_product(n, 1) < wide_product(baud * baud, d);
                if (better) begin
                  have = 1'b1;
                  best_n = n;
                  best_d = d;
                  res.dl = dlv[DL_W-1:0];
                  res.da = dav[DA_W-1:0];
                  res.mul = mv[MUL_W-1:0];
                  // under 1/1000: stop once this divisor is done
                  if (wide_product(n, 1000) < wide_product(baud, d)) hit = 1'b1;
                end
              end
            end
          end
        end
      end
      return res;
    endfunction

    function void note_request(logic [BAUD_W-1:0] baud_rate);
      expected_divisors.push_back(compute_divisors(baud_rate));
    endfunction

    function string check_result(divisor_set_t got);
      divisor_set_t want;
      string msg;
      msg = "";
      if (expected_divisors.size() == 0)
        return $sformatf("result dl=%0d da=%0d mul=%0d with no request waiting",
                         got.dl, got.da, got.mul);
      want = expected_divisors.pop_front();
      if (got.dl !== want.dl)
        msg = {msg, $sformatf(" divisor_latch got %0d want %0d", got.dl, want.dl)};
      if (got.da !== want.da)
        msg = {msg, $sformatf(" div_add got %0d want %0d", got.da, want.da)};
      if (got.mul !== want.mul)
        msg = {msg, $sformatf(" multiplier got %0d want %0d", got.mul, want.mul)};
      return msg;
    endfunction

    function int pending();
      return expected_divisors.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ufbs_cfg_if cfg_ch ();
  ufbs_in_if  in_ch ();
  ufbs_out_if out_ch ();

  uart_fractional_baud_search_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  divisor_scoreboard sb;
  int                mismatches = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  logic [BAUD_W-1:0] batch[$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch:%s", $time, msg);
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // New clock setting, idling and stalling mode; only called with the block idle
  task automatic start_phase(input logic [CLK_W-1:0] clock_hz, input int unsigned idle_pct,
                             input int unsigned stall);
    drain_results();
    send_idle_pct = idle_pct;
    stall_pct = stall;
    @(negedge clk_i);
    cfg_ch.valid = 1'b1;
    cfg_ch.clock_hz = clock_hz;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    sb.clock_hz = clock_hz;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_baud(input logic [BAUD_W-1:0] baud_rate);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.baud_rate = baud_rate;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_request(baud_rate);
  endtask

  task automatic send_batch();
    foreach (batch[i]) send_baud(batch[i]);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  // Mostly rates a few divisor steps below clock/16, some raw noise; the search
  // cost grows with the quotient, so it is kept small.
  function automatic logic [BAUD_W-1:0] random_baud(longint unsigned clk);
    longint unsigned base, spread, v;
    int unsigned qt;
    if ($urandom_range(99) < 70) begin
      qt = $urandom_range(1, 6);
      base = clk / (16 * qt);
      spread = base / 8;
      v = base - spread + $urandom_range(0, 2 * spread);
    end else begin
      do v = $urandom_range(0, 24'hFFFFFF); while (v != 0 && clk / (16 * v) > 12);
    end
    return v[BAUD_W-1:0];
  endfunction

  initial begin : result_sink
    divisor_set_t got;
    string msg;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = ($urandom_range(99) >= stall_pct);
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        got = '{dl: out_ch.divisor_latch, da: out_ch.div_add, mul: out_ch.multiplier};
        msg = sb.check_result(got);
        if (msg != "") report_mismatch(msg);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [CLK_W-1:0] clk_setting;
    sb = new();
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.baud_rate = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.clock_hz = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset clock: zero rate, saturated exact quotient, rate above clock/16,
    // exact and inexact small quotients, real searches
    batch = '{24'd0, 24'd1, 24'd3750000, 24'd3750001, 24'hFFFFFF, 24'd2500000,
              24'd3125000, 24'd468750, 24'd500000, 24'd115200, 24'd9600};
    send_batch();

    start_phase(CLK_W'(1000000), 0, 0);
    batch = '{24'd300, 24'd1200, 24'd62500, 24'd62501, 24'h800000};
    send_batch();

    start_phase(CLK_W'(200000000), 0, 0);
    batch = '{24'd1, 24'd5, 24'd12500000, 24'd12499999, 24'd4000000, 24'd921600,
              24'h7FFFFF};
    send_batch();

    for (int p = 0; p < 8; p++) begin
      if (p == 0)
        clk_setting = CLK_W'(200000000);
      else if (p == 1)
        clk_setting = CLK_W'(1000000);
      else
        clk_setting = CLK_W'($urandom_range(1000000, 200000000));
      case (p % 4)
        0: start_phase(clk_setting, 0, 0);
        1: start_phase(clk_setting, 84, 0);
        2: start_phase(clk_setting, 0, 84);
        default: start_phase(clk_setting, 36, 36);
      endcase
      batch.delete();
      repeat (12) batch.push_back(random_baud(clk_setting));
      send_batch();
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    if (sb.pending() != 0)
      report_mismatch($sformatf(" %0d results never arrived", sb.pending()));
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: uart_fractional_baud_search_core.f
hdl/ufbs_pkg.sv
hdl/ufbs_if.sv
hdl/ufbs_xcmp.sv
hdl/uart_fractional_baud_search_core.sv
hdl/ufbs_checker.sv
bench/uart_fractional_baud_search_core_test.sv
